// File: src/nnis_pkg.sv
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int COLOR_W   = 8;
  localparam int COORD_W   = 15;
  localparam int SCALE_W   = 4;
  localparam int DIM_CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COLS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_ROWS = 2'd3;

  localparam logic MODE_DOWN = 1'b0;
  localparam logic MODE_UP   = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [SCALE_W-1:0]   scale;
    logic [DIM_CFG_W-1:0] in_cols;
    logic [DIM_CFG_W-1:0] in_rows;
  } cfg_t;

  // one queued source pixel with its first output coordinate and per-axis copy count
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SCALE_W-1:0] reps;
  } job_t;

endpackage

// File: src/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Integer nearest-neighbor scaler for a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Source pixels are taken one per clock in raster order while in_stall is low.
// In down mode a pixel is kept only at the top-left corner of a whole
// scale-by-scale block and gives one transaction; in up mode it gives
// scale*scale transactions in row-major order, the last one flagged by
// out_run_end. Down mode sustains one pixel per clock unless stalled; in up
// mode the back-end replication counter emits one copy per clock unless
// out_stall is high. A two-entry queue separates intake from the output
// register. Configuration takes effect from the next pixel; frame counters
// are not cleared by a write.
module nearest_neighbor_image_scaler #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_SCALE = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_red,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_green,
  input  logic [nnis_pkg::COLOR_W-1:0]    in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nnis_pkg::COLOR_W-1:0]    out_red,
  output logic [nnis_pkg::COLOR_W-1:0]    out_green,
  output logic [nnis_pkg::COLOR_W-1:0]    out_blue,
  output logic [nnis_pkg::COORD_W-1:0]    out_row,
  output logic [nnis_pkg::COORD_W-1:0]    out_col,
  output logic                            out_run_end
);

  nnis_pkg::cfg_t cfg_r;
  nnis_pkg::job_t push_job;
  nnis_pkg::job_t head;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= nnis_pkg::MODE_DOWN;
      cfg_r.scale   <= nnis_pkg::SCALE_W'(1);
      cfg_r.in_cols <= nnis_pkg::DIM_CFG_W'(640);
      cfg_r.in_rows <= nnis_pkg::DIM_CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        nnis_pkg::REG_MODE:    cfg_r.mode    <= cfg_data[0];
        nnis_pkg::REG_SCALE:   cfg_r.scale   <= cfg_data[nnis_pkg::SCALE_W-1:0];
        nnis_pkg::REG_IN_COLS: cfg_r.in_cols <= cfg_data[nnis_pkg::DIM_CFG_W-1:0];
        nnis_pkg::REG_IN_ROWS: cfg_r.in_rows <= cfg_data[nnis_pkg::DIM_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;

  nnis_front #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .push     (push),
    .job      (push_job)
  );

  nnis_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  nnis_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .empty       (q_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_run_end (out_run_end)
  );

endmodule

// File: src/nnis_front.sv
// ----------------------------------------------------------------------------
// nnis_front
// Accepts source pixels, tracks frame position and builds queue entries.
// ----------------------------------------------------------------------------
module nnis_front #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_SCALE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnis_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic                          q_full,
  input  logic [nnis_pkg::COLOR_W-1:0]  in_red,
  input  logic [nnis_pkg::COLOR_W-1:0]  in_green,
  input  logic [nnis_pkg::COLOR_W-1:0]  in_blue,
  output logic                          push,
  output nnis_pkg::job_t                job
);

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = DIM_W + 1;
  localparam int SUM_W  = DIM_W + 2;
  localparam int EXT_W  = (CNT_W > nnis_pkg::DIM_CFG_W) ? CNT_W : nnis_pkg::DIM_CFG_W;
  localparam int PH_W   = $clog2(MAX_SCALE);
  localparam int SCL_W  = $clog2(MAX_SCALE + 1);
  localparam int PROD_W = DIM_W + SCL_W;

  logic [DIM_W-1:0] src_row_r, src_row_nxt;
  logic [DIM_W-1:0] src_col_r, src_col_nxt;
  logic [DIM_W-1:0] dst_row_r, dst_row_nxt;
  logic [DIM_W-1:0] dst_col_r, dst_col_nxt;
  logic [PH_W-1:0]  row_ph_r, row_ph_nxt;
  logic [PH_W-1:0]  col_ph_r, col_ph_nxt;

  logic [nnis_pkg::SCALE_W-1:0] scale_cl;
  logic [SCL_W-1:0]             s;
  logic [EXT_W-1:0]             cols_x, rows_x;
  logic [CNT_W-1:0]             cols, rows;
  logic                         accept;
  logic                         keep;
  logic [PROD_W-1:0]            up_row, up_col;

  always_comb begin
    if (cfg.scale == '0) begin
      scale_cl = nnis_pkg::SCALE_W'(1);
    end else if (cfg.scale > nnis_pkg::SCALE_W'(MAX_SCALE)) begin
      scale_cl = nnis_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      scale_cl = cfg.scale;
    end
    s = SCL_W'(scale_cl);

    cols_x = EXT_W'(cfg.in_cols);
    if (cols_x == '0) begin
      cols_x = EXT_W'(1);
    end else if (cols_x > EXT_W'(MAX_DIM)) begin
      cols_x = EXT_W'(MAX_DIM);
    end
    cols = CNT_W'(cols_x);

    rows_x = EXT_W'(cfg.in_rows);
    if (rows_x == '0) begin
      rows_x = EXT_W'(1);
    end else if (rows_x > EXT_W'(MAX_DIM)) begin
      rows_x = EXT_W'(MAX_DIM);
    end
    rows = CNT_W'(rows_x);
  end

  assign accept = in_valid && !q_full;

  always_comb begin
    keep = (row_ph_r == '0) && (col_ph_r == '0) &&
           (SUM_W'(src_row_r) + SUM_W'(s) <= SUM_W'(rows)) &&
           (SUM_W'(src_col_r) + SUM_W'(s) <= SUM_W'(cols));
    up_row = PROD_W'(src_row_r) * PROD_W'(s);
    up_col = PROD_W'(src_col_r) * PROD_W'(s);

    job.red   = in_red;
    job.green = in_green;
    job.blue  = in_blue;
    if (cfg.mode == nnis_pkg::MODE_UP) begin
      job.row  = nnis_pkg::COORD_W'(up_row);
      job.col  = nnis_pkg::COORD_W'(up_col);
      job.reps = scale_cl;
    end else begin
      job.row  = nnis_pkg::COORD_W'(dst_row_r);
      job.col  = nnis_pkg::COORD_W'(dst_col_r);
      job.reps = nnis_pkg::SCALE_W'(1);
    end
    push = accept && ((cfg.mode == nnis_pkg::MODE_UP) || keep);
  end

  // position counters
  always_comb begin
    src_row_nxt = src_row_r;
    src_col_nxt = src_col_r;
    dst_row_nxt = dst_row_r;
    dst_col_nxt = dst_col_r;
    row_ph_nxt  = row_ph_r;
    col_ph_nxt  = col_ph_r;
    if (accept) begin
      if (SCL_W'(col_ph_r) + SCL_W'(1) >= s) begin
        col_ph_nxt  = '0;
        dst_col_nxt = dst_col_r + DIM_W'(1);
      end else begin
        col_ph_nxt = col_ph_r + PH_W'(1);
      end
      if (CNT_W'(src_col_r) + CNT_W'(1) >= cols) begin
        src_col_nxt = '0;
        col_ph_nxt  = '0;
        dst_col_nxt = '0;
        if (SCL_W'(row_ph_r) + SCL_W'(1) >= s) begin
          row_ph_nxt  = '0;
          dst_row_nxt = dst_row_r + DIM_W'(1);
        end else begin
          row_ph_nxt = row_ph_r + PH_W'(1);
        end
        if (CNT_W'(src_row_r) + CNT_W'(1) >= rows) begin
          src_row_nxt = '0;
          row_ph_nxt  = '0;
          dst_row_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + DIM_W'(1);
        end
      end else begin
        src_col_nxt = src_col_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_row_r <= '0;
      src_col_r <= '0;
      dst_row_r <= '0;
      dst_col_r <= '0;
      row_ph_r  <= '0;
      col_ph_r  <= '0;
    end else begin
      src_row_r <= src_row_nxt;
      src_col_r <= src_col_nxt;
      dst_row_r <= dst_row_nxt;
      dst_col_r <= dst_col_nxt;
      row_ph_r  <= row_ph_nxt;
      col_ph_r  <= col_ph_nxt;
    end
  end

endmodule

// File: src/nnis_fifo.sv
// ----------------------------------------------------------------------------
// nnis_fifo
// Short queue of pixel entries between the front and back ends.
// ----------------------------------------------------------------------------
module nnis_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nnis_pkg::job_t push_job,
  input  logic           pop,
  output nnis_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = $clog2(nnis_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(nnis_pkg::QUEUE_DEPTH + 1);

  nnis_pkg::job_t   q_r [nnis_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(nnis_pkg::QUEUE_DEPTH));
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(nnis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: src/nnis_back.sv
// ----------------------------------------------------------------------------
// nnis_back
// Replicates each queued pixel over its block and drives the output register.
// ----------------------------------------------------------------------------
module nnis_back #(
  parameter int MAX_SCALE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnis_pkg::job_t                head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [nnis_pkg::COLOR_W-1:0]  out_red,
  output logic [nnis_pkg::COLOR_W-1:0]  out_green,
  output logic [nnis_pkg::COLOR_W-1:0]  out_blue,
  output logic [nnis_pkg::COORD_W-1:0]  out_row,
  output logic [nnis_pkg::COORD_W-1:0]  out_col,
  output logic                          out_run_end
);

  localparam int PH_W = $clog2(MAX_SCALE);

  logic [PH_W-1:0] a_r, a_nxt;
  logic [PH_W-1:0] b_r, b_nxt;
  logic            valid_r, valid_nxt;
  logic            load;
  logic            last_b;
  logic            last_a;

  logic [nnis_pkg::COLOR_W-1:0] red_r, green_r, blue_r;
  logic [nnis_pkg::COORD_W-1:0] row_r, col_r;
  logic                         run_end_r;

  assign load   = !empty && (!valid_r || !out_stall);
  assign last_b = (nnis_pkg::SCALE_W'(b_r) == head.reps - nnis_pkg::SCALE_W'(1));
  assign last_a = (nnis_pkg::SCALE_W'(a_r) == head.reps - nnis_pkg::SCALE_W'(1));
  assign pop    = load && last_a && last_b;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (last_b) begin
        b_nxt = '0;
        a_nxt = last_a ? '0 : a_r + PH_W'(1);
      end else begin
        b_nxt = b_r + PH_W'(1);
      end
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r     <= head.red;
      green_r   <= head.green;
      blue_r    <= head.blue;
      row_r     <= head.row + nnis_pkg::COORD_W'(a_r);
      col_r     <= head.col + nnis_pkg::COORD_W'(b_r);
      run_end_r <= last_a && last_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= '0;
      b_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_red     = red_r;
  assign out_green   = green_r;
  assign out_blue    = blue_r;
  assign out_row     = row_r;
  assign out_col     = col_r;
  assign out_run_end = run_end_r;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
// Source pixels are queued by the stimulus process and driven by a clocked
// driver. Every accepted pixel is run through a scaler model that keeps its
// own frame position, so the expected decimated or replicated pixels are
// known. A clocked monitor compares each output transaction with the oldest
// expected pixel. Formats change only while the scaler is drained. A short
// directed part covers clamped scale and sizes, dropped remainders and frame
// wrap. Random bursts with random formats follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_DIM       = 4096;
  localparam int MAX_SCALE     = 8;
  localparam int RANDOM_PIXELS = 480;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [nnis_pkg::COLOR_W-1:0] red;
    logic [nnis_pkg::COLOR_W-1:0] green;
    logic [nnis_pkg::COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [nnis_pkg::COLOR_W-1:0] red;
    logic [nnis_pkg::COLOR_W-1:0] green;
    logic [nnis_pkg::COLOR_W-1:0] blue;
    logic [nnis_pkg::COORD_W-1:0] row;
    logic [nnis_pkg::COORD_W-1:0] col;
    logic                         run_end;
  } scaled_pixel_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index = nnis_pkg::REG_MODE;
  logic [nnis_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [nnis_pkg::COLOR_W-1:0]   in_red    = '0;
  logic [nnis_pkg::COLOR_W-1:0]   in_green  = '0;
  logic [nnis_pkg::COLOR_W-1:0]   in_blue   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [nnis_pkg::COLOR_W-1:0]   out_red;
  logic [nnis_pkg::COLOR_W-1:0]   out_green;
  logic [nnis_pkg::COLOR_W-1:0]   out_blue;
  logic [nnis_pkg::COORD_W-1:0]   out_row;
  logic [nnis_pkg::COORD_W-1:0]   out_col;
  logic                           out_run_end;

  // scaler format as last written
  logic                           scl_mode     = nnis_pkg::MODE_DOWN;
  logic [nnis_pkg::SCALE_W-1:0]   scl_factor   = 4'd1;
  logic [nnis_pkg::DIM_CFG_W-1:0] frame_width  = 13'd640;
  logic [nnis_pkg::DIM_CFG_W-1:0] frame_height = 13'd480;

  // position of the next source pixel
  logic [15:0] line_idx  = '0;
  logic [15:0] pixel_idx = '0;
  logic [15:0] vphase    = '0;
  logic [15:0] hphase    = '0;
  logic [15:0] kept_row  = '0;
  logic [15:0] kept_col  = '0;

  rgb_t          pending_pixels[$];
  scaled_pixel_t scaled_pixels_due[$];
  scaled_pixel_t due_px;
  rgb_t          next_px;

  int  send_gap_pct   = 19;
  int  recv_stall_pct = 87;
  int  quiet_cycles   = 0;
  bit  failed         = 1'b0;

  nearest_neighbor_image_scaler #(
    .MAX_DIM   (MAX_DIM),
    .MAX_SCALE (MAX_SCALE)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_run_end (out_run_end)
  );

  always #1 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [nnis_pkg::DIM_CFG_W-1:0] d);
    if (d < 1) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  task automatic scale_pixel(input rgb_t px);
    int unsigned   s;
    int unsigned   cols;
    int unsigned   rows;
    int unsigned   r;
    int unsigned   c;
    scaled_pixel_t res;
    s = (scl_factor < 1) ? 1 : (scl_factor > MAX_SCALE) ? MAX_SCALE : scl_factor;
    cols = clamp_dim(frame_width);
    rows = clamp_dim(frame_height);
    res.red = px.red;
    res.green = px.green;
    res.blue = px.blue;
    if (scl_mode == nnis_pkg::MODE_DOWN) begin
      if (vphase == 0 && hphase == 0 && line_idx + s <= rows && pixel_idx + s <= cols) begin
        res.row = kept_row[nnis_pkg::COORD_W-1:0];
        res.col = kept_col[nnis_pkg::COORD_W-1:0];
        res.run_end = 1'b1;
        scaled_pixels_due.push_back(res);
      end
    end else begin
      for (int a = 0; a < s; a++) begin
        for (int b = 0; b < s; b++) begin
          r = line_idx * s + a;
          c = pixel_idx * s + b;
          res.row = r[nnis_pkg::COORD_W-1:0];
          res.col = c[nnis_pkg::COORD_W-1:0];
          res.run_end = (a + 1 == s) && (b + 1 == s);
          scaled_pixels_due.push_back(res);
        end
      end
    end
    if (hphase + 1 >= s) begin
      hphase = '0;
      kept_col = kept_col + 1'b1;
    end else begin
      hphase = hphase + 1'b1;
    end
    if (pixel_idx + 1 >= cols) begin
      pixel_idx = '0;
      hphase = '0;
      kept_col = '0;
      if (vphase + 1 >= s) begin
        vphase = '0;
        kept_row = kept_row + 1'b1;
      end else begin
        vphase = vphase + 1'b1;
      end
      if (line_idx + 1 >= rows) begin
        line_idx = '0;
        vphase = '0;
        kept_row = '0;
      end else begin
        line_idx = line_idx + 1'b1;
      end
    end else begin
      pixel_idx = pixel_idx + 1'b1;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scale_pixel({in_red, in_green, in_blue});
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_px = pending_pixels.pop_front();
          in_valid <= 1'b1;
          in_red <= next_px.red;
          in_green <= next_px.green;
          in_blue <= next_px.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (scaled_pixels_due.size() == 0) begin
          $error("unexpected transaction: row %0d col %0d", out_row, out_col);
          failed = 1'b1;
        end else begin
          due_px = scaled_pixels_due.pop_front();
          check_field("out_red", due_px.red, out_red);
          check_field("out_green", due_px.green, out_green);
          check_field("out_blue", due_px.blue, out_blue);
          check_field("out_row", due_px.row, out_row);
          check_field("out_col", due_px.col, out_col);
          check_field("out_run_end", due_px.run_end, out_run_end);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || in_valid || scaled_pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[nnis_pkg::CFG_DAT_W-1:0];
    case (idx)
      nnis_pkg::REG_MODE:    scl_mode = value[0];
      nnis_pkg::REG_SCALE:   scl_factor = value[nnis_pkg::SCALE_W-1:0];
      nnis_pkg::REG_IN_COLS: frame_width = value[nnis_pkg::DIM_CFG_W-1:0];
      nnis_pkg::REG_IN_ROWS: frame_height = value[nnis_pkg::DIM_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic mode, input int unsigned factor,
                            input int unsigned width, input int unsigned height);
    write_reg(nnis_pkg::REG_MODE, {31'd0, mode});
    write_reg(nnis_pkg::REG_SCALE, factor);
    write_reg(nnis_pkg::REG_IN_COLS, width);
    write_reg(nnis_pkg::REG_IN_ROWS, height);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
    pending_pixels.push_back({r[nnis_pkg::COLOR_W-1:0], g[nnis_pkg::COLOR_W-1:0],
                              b[nnis_pkg::COLOR_W-1:0]});
  endtask

  function automatic int unsigned pick_dim();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel < 16) return $urandom_range(1, 12);
    if (sel == 16) return 0;
    if (sel == 17) return MAX_DIM;
    if (sel == 18) return 8191;
    return $urandom_range(8191);
  endfunction

  initial begin
    int unsigned issued;
    int unsigned burst;
    int unsigned factor;
    issued = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero scale and zero sizes clamp to one, every pixel closes a frame
    set_format(nnis_pkg::MODE_UP, 0, 0, 0);
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(8'hAA, 8'h55, 8'hAA);
    wait_drained();

    // 3x3 frame at scale 2: remainder rows and columns dropped
    set_format(nnis_pkg::MODE_DOWN, 2, 3, 3);
    for (int k = 0; k < 4; k++) queue_pixel(255 - k, k * 40, 8'h55 + k);
    wait_drained();
    for (int k = 4; k < 9; k++) queue_pixel(255 - k, k * 30, 8'hAA - k);
    wait_drained();

    // oversized scale and sizes clamp to the maximum
    set_format(nnis_pkg::MODE_UP, 15, 8191, 8191);
    queue_pixel(255, 0, 255);
    queue_pixel(0, 255, 0);
    wait_drained();

    set_format(nnis_pkg::MODE_DOWN, 1, MAX_DIM, 2);
    queue_pixel(1, 2, 3);
    queue_pixel(254, 253, 252);
    queue_pixel(128, 127, 64);
    queue_pixel(63, 192, 31);
    wait_drained();

    while (issued < RANDOM_PIXELS) begin
      if (issued < RANDOM_PIXELS / 3) begin
        send_gap_pct = 19;
        recv_stall_pct = 87;
      end else if (issued < 2 * RANDOM_PIXELS / 3) begin
        send_gap_pct = 87;
        recv_stall_pct = 19;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      factor = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(15);
      set_format(1'($urandom_range(1)), factor, pick_dim(), pick_dim());
      burst = $urandom_range(15, 45);
      if (burst > RANDOM_PIXELS - issued) burst = RANDOM_PIXELS - issued;
      for (int k = 0; k < burst; k++) begin
        queue_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
        if (k == burst / 2 && $urandom_range(3) == 0) wait_drained();
      end
      issued = issued + burst;
      wait_drained();
    end

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
